FILE: rtl/gsrp_pkg.sv
`timescale 1ns / 1ps

package gsrp_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned BitIndexWidth = 5;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned CsrAddrWidth = 3;

   localparam logic [ByteWidth-1:0] LatchTicksReset = 8'd12;
   localparam logic [ByteWidth-1:0] HalfBitTicksReset = 8'd6;

   localparam logic [ByteWidth-1:0] AxisCenter = 8'd128;
   localparam logic [ByteWidth-1:0] AxisPlus = 8'd255;
   localparam logic [ByteWidth-1:0] AxisMinus = 8'd0;

   localparam logic [BitIndexWidth-1:0] BitsPerByte = 5'd8;
   localparam logic [BitIndexWidth-1:0] BitsPerPoll = 5'd16;

   typedef enum logic [0:0] {
      REG_LATCH_TICKS = 1'b0,
      REG_HALF_BIT_TICKS = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_LATCH = 2'd1,
      PH_HIGH = 2'd2,
      PH_LOW = 2'd3
   } phase_type;

   typedef struct packed {
      logic start_poll;
      logic pin_level;
   } req_type;

   typedef struct packed {
      logic                 latch_out;
      logic                 clock_out;
      logic                 busy_res;
      logic                 report_valid;
      logic [ByteWidth-1:0] axis_x;
      logic [ByteWidth-1:0] axis_y;
      logic [ByteWidth-1:0] buttons;
      logic                 extra_button;
      logic                 changed;
   } rsp_type;

   typedef struct packed {
      logic [ByteWidth-1:0] latch_ticks;
      logic [ByteWidth-1:0] half_bit_ticks;
   } cfg_type;

   function automatic logic [ByteWidth-1:0] axis_value(input logic plus, input logic minus);
      logic [ByteWidth-1:0] v;
      v = AxisCenter;
      if (plus) begin
         v = AxisPlus;
      end
      if (minus) begin
         v = AxisMinus;
      end
      return v;
   endfunction

endpackage

FILE: rtl/gsrp_sequencer.sv
`timescale 1ns / 1ps

module gsrp_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  gsrp_pkg::req_type req,
   input  gsrp_pkg::cfg_type cfg,
   output gsrp_pkg::rsp_type rsp
);
   import gsrp_pkg::*;

   phase_type                phase_ff, phase_in;
   logic [ByteWidth-1:0]     tick_count_ff, tick_count_in;
   logic [BitIndexWidth-1:0] bit_index_ff, bit_index_in;
   logic [ByteWidth-1:0]     shift_byte_ff, shift_byte_in;
   logic [ByteWidth-1:0]     first_byte_ff, first_byte_in;
   logic [ByteWidth-1:0]     prev0_ff, prev1_ff;

   logic [ByteWidth-1:0]     tick_inc;
   logic                     latch_done;
   logic                     half_done;
   logic                     pressed;
   logic                     report;
   logic [BitIndexWidth-1:0] bit_next;

   assign tick_inc = tick_count_ff + 8'd1;
   assign latch_done = (tick_inc >= cfg.latch_ticks);
   assign half_done = (tick_inc >= cfg.half_bit_ticks);
   assign pressed = ~req.pin_level;
   assign bit_next = bit_index_ff + 5'd1;

   always_comb begin
      phase_in = phase_ff;
      tick_count_in = tick_count_ff;
      bit_index_in = bit_index_ff;
      shift_byte_in = shift_byte_ff;
      first_byte_in = first_byte_ff;
      report = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (req.start_poll) begin
               phase_in = PH_LATCH;
               tick_count_in = '0;
               bit_index_in = '0;
               shift_byte_in = '0;
            end
         end
         PH_LATCH: begin
            tick_count_in = tick_inc;
            if (latch_done) begin
               tick_count_in = '0;
               phase_in = PH_HIGH;
            end
         end
         PH_HIGH: begin
            tick_count_in = tick_inc;
            if (half_done) begin
               tick_count_in = '0;
               phase_in = PH_LOW;
               if (bit_index_ff < BitsPerByte) begin
                  shift_byte_in = {shift_byte_ff[ByteWidth-2:0], pressed};
               end else begin
                  shift_byte_in = {pressed, shift_byte_ff[ByteWidth-1:1]};
               end
               bit_index_in = bit_next;
               if (bit_next == BitsPerByte) begin
                  first_byte_in = shift_byte_in;
               end
            end
         end
         default: begin
            tick_count_in = tick_inc;
            if (half_done) begin
               tick_count_in = '0;
               phase_in = PH_HIGH;
               if (bit_index_ff >= BitsPerPoll) begin
                  phase_in = PH_IDLE;
                  bit_index_in = '0;
                  report = 1'b1;
               end
            end
         end
      endcase
   end

   always_comb begin
      rsp = '0;
      rsp.latch_out = (phase_in == PH_LATCH);
      rsp.clock_out = (phase_in != PH_LOW);
      rsp.busy_res = (phase_in != PH_IDLE);
      if (report) begin
         rsp.report_valid = 1'b1;
         rsp.axis_x = axis_value(first_byte_ff[0], first_byte_ff[1]);
         rsp.axis_y = axis_value(first_byte_ff[2], first_byte_ff[3]);
         rsp.buttons = {shift_byte_ff[3:0], first_byte_ff[4], first_byte_ff[5],
                        first_byte_ff[6], first_byte_ff[7]};
         rsp.extra_button = shift_byte_ff[4];
         rsp.changed = (first_byte_ff != prev0_ff) || (shift_byte_ff != prev1_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_count_ff <= '0;
         bit_index_ff <= '0;
         shift_byte_ff <= '0;
         first_byte_ff <= '0;
         prev0_ff <= '0;
         prev1_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_count_ff <= tick_count_in;
         bit_index_ff <= bit_index_in;
         shift_byte_ff <= shift_byte_in;
         first_byte_ff <= first_byte_in;
         if (report) begin
            prev0_ff <= first_byte_ff;
            prev1_ff <= shift_byte_ff;
         end
      end
   end

`ifndef SYNTHESIS
   a_idle_index_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> bit_index_ff == '0)
      else $error("bit index not cleared while idle");
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      bit_index_ff <= BitsPerPoll)
      else $error("bit index ran past the last bit");
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_IDLE && !req.start_poll |=> phase_ff == PH_IDLE)
      else $error("poll started without a request");
`endif

endmodule

FILE: rtl/gsrp_skid.sv
`timescale 1ns / 1ps

module gsrp_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  gsrp_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output gsrp_pkg::rsp_type out_data
);
   import gsrp_pkg::*;

   logic    out_valid_ff;
   logic    skid_valid_ff;
   rsp_type out_data_ff;
   rsp_type skid_data_ff;
   logic    pop;
   logic    push;

   assign in_ready = ~skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data = out_data_ff;
   assign pop = out_valid_ff & out_ready;
   assign push = in_valid & ~skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_data_ff <= in_data;
         end else begin
            out_data_ff <= in_data;
         end
      end
   end

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage full while output register empty");
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !pop |=> skid_valid_ff && $stable(skid_data_ff))
      else $error("skid item lost while output stalled");
   a_push_into_skid: assert property (@(posedge clock) disable iff (reset)
      push && out_valid_ff && !out_ready |=> skid_valid_ff)
      else $error("item accepted under stall not kept");
`endif

endmodule

FILE: rtl/gamepad_shift_register_poller.sv
`timescale 1ns / 1ps

// Polls a shift-register gamepad, one input item per timebase tick, and gives exactly one
// result item per input item, which is registered once accepted. The line sequencer updates
// its state in the cycle an item is accepted, so an item can be taken every cycle; a
// result register with a one-item skid stage behind it means req_ready drops only after
// two results wait untaken. Registers at byte address 0 (latch_ticks) and 4
// (half_bit_ticks) are written through the APB-style port and read back zero-extended.
module gamepad_shift_register_poller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  gsrp_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output gsrp_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [gsrp_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [gsrp_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [gsrp_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import gsrp_pkg::*;

   logic [ByteWidth-1:0] latch_ticks_ff;
   logic [ByteWidth-1:0] half_bit_ticks_ff;
   cfg_type              cfg;
   rsp_type              step_rsp;
   logic                 step;
   logic                 csr_write;
   reg_index_type        csr_index;

   assign csr_pready = 1'b1;
   assign csr_index = reg_index_type'(csr_paddr[2]);
   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg.latch_ticks = latch_ticks_ff;
   assign cfg.half_bit_ticks = half_bit_ticks_ff;
   assign step = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ticks_ff <= LatchTicksReset;
         half_bit_ticks_ff <= HalfBitTicksReset;
      end else if (csr_write) begin
         case (csr_index)
            REG_LATCH_TICKS: latch_ticks_ff <= csr_pwdata[ByteWidth-1:0];
            REG_HALF_BIT_TICKS: half_bit_ticks_ff <= csr_pwdata[ByteWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_LATCH_TICKS: csr_prdata = {{(CsrDataWidth-ByteWidth){1'b0}}, latch_ticks_ff};
         REG_HALF_BIT_TICKS:
            csr_prdata = {{(CsrDataWidth-ByteWidth){1'b0}}, half_bit_ticks_ff};
         default: csr_prdata = '0;
      endcase
   end

   gsrp_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_data),
      .cfg   (cfg),
      .rsp   (step_rsp)
   );

   gsrp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (step_rsp),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import gsrp_pkg::*;

   logic clock;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [CsrDataWidth-1:0] csr_pwdata = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic csr_pready;

   gamepad_shift_register_poller uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Mirror of the poller: line sequencer state and the two timing registers.
   logic [ByteWidth-1:0] cfg_latch_ticks = LatchTicksReset;
   logic [ByteWidth-1:0] cfg_half_ticks = HalfBitTicksReset;
   phase_type pad_phase = PH_IDLE;
   logic [ByteWidth-1:0] pad_ticks = '0;
   logic [BitIndexWidth-1:0] pad_bit = '0;
   logic [ByteWidth-1:0] pad_shift = '0;
   logic [ByteWidth-1:0] pad_first = '0;
   logic [ByteWidth-1:0] reported_bytes [2] = '{8'd0, 8'd0};

   rsp_type outputs_due[$];
   int failures = 0;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   logic stall_request = 1'b0;
   int stall_left = 0;
   logic [15:0] last_buttons = '0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic logic interval_over(logic [ByteWidth-1:0] len);
      pad_ticks = pad_ticks + 8'd1;
      if (pad_ticks >= len) begin
         pad_ticks = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic rsp_type advance_poller(req_type item);
      rsp_type r;
      logic pressed;
      logic report_now;
      logic [ByteWidth-1:0] b0;
      logic [ByteWidth-1:0] b1;
      r = '0;
      report_now = 1'b0;
      b0 = '0;
      b1 = '0;
      pressed = ~item.pin_level;
      case (pad_phase)
         PH_IDLE: begin
            if (item.start_poll) begin
               pad_phase = PH_LATCH;
               pad_ticks = '0;
               pad_bit = '0;
               pad_shift = '0;
            end
         end
         PH_LATCH: begin
            if (interval_over(cfg_latch_ticks)) pad_phase = PH_HIGH;
         end
         PH_HIGH: begin
            if (interval_over(cfg_half_ticks)) begin
               pad_phase = PH_LOW;
               if (pad_bit < BitsPerByte) pad_shift = {pad_shift[6:0], pressed};
               else pad_shift = {pressed, pad_shift[7:1]};
               pad_bit = pad_bit + 5'd1;
               if (pad_bit == BitsPerByte) pad_first = pad_shift;
            end
         end
         default: begin
            if (interval_over(cfg_half_ticks)) begin
               pad_phase = PH_HIGH;
               if (pad_bit >= BitsPerPoll) begin
                  pad_phase = PH_IDLE;
                  pad_bit = '0;
                  report_now = 1'b1;
                  b0 = pad_first;
                  b1 = pad_shift;
               end
            end
         end
      endcase
      r.latch_out = (pad_phase == PH_LATCH);
      r.clock_out = (pad_phase != PH_LOW);
      r.busy_res = (pad_phase != PH_IDLE);
      if (report_now) begin
         r.report_valid = 1'b1;
         r.axis_x = b0[1] ? 8'd0 : (b0[0] ? 8'd255 : 8'd128);
         r.axis_y = b0[3] ? 8'd0 : (b0[2] ? 8'd255 : 8'd128);
         r.buttons = {b1[3:0], b0[4], b0[5], b0[6], b0[7]};
         r.extra_button = b1[4];
         r.changed = (b0 != reported_bytes[0]) || (b1 != reported_bytes[1]);
         reported_bytes[0] = b0;
         reported_bytes[1] = b1;
      end
      return r;
   endfunction

   task automatic note_failure(string what);
      failures++;
      if (failures <= 10) begin
         $display("%0t: %s", $realtime, what);
      end
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         note_failure($sformatf("Mismatch on %s: expected %0d, got %0d", name, want, got));
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (outputs_due.size() == 0) begin
            note_failure("Output item arrived with no prediction pending");
         end else begin
            want = outputs_due.pop_front();
            check_field("latch_out", want.latch_out, rsp_data.latch_out);
            check_field("clock_out", want.clock_out, rsp_data.clock_out);
            check_field("busy_res", want.busy_res, rsp_data.busy_res);
            check_field("report_valid", want.report_valid, rsp_data.report_valid);
            check_field("axis_x", want.axis_x, rsp_data.axis_x);
            check_field("axis_y", want.axis_y, rsp_data.axis_y);
            check_field("buttons", want.buttons, rsp_data.buttons);
            check_field("extra_button", want.extra_button, rsp_data.extra_button);
            check_field("changed", want.changed, rsp_data.changed);
         end
      end
   end

   // The receiver counts out a long hold-off on request, otherwise idles at random.
   always @(posedge clock) begin
      if (stall_request) begin
         stall_request <= 1'b0;
         stall_left = 300;
      end
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   task automatic send_tick(req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      outputs_due.push_back(advance_poller(item));
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outputs_due.size() != 0);
   endtask

   task automatic program_register(reg_index_type which, logic [ByteWidth-1:0] value);
      wait_until_drained();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {which, 2'b00};
      csr_pwdata <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("register readback", {24'd0, value}, csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (which == REG_LATCH_TICKS) cfg_latch_ticks = value;
      else cfg_half_ticks = value;
   endtask

   // Pin pattern, in shift order, that makes the poller read bytes b0 and b1.
   function automatic logic [15:0] line_order(logic [7:0] b0, logic [7:0] b1);
      logic [15:0] bits;
      for (int j = 0; j < 8; j++) bits[7-j] = b0[j];
      bits[15:8] = b1;
      return bits;
   endfunction

   function automatic logic [15:0] choose_buttons();
      case ($urandom_range(5))
         0: ;
         1: last_buttons = 16'h0000;
         2: last_buttons = 16'hffff;
         default: last_buttons = 16'($urandom);
      endcase
      return last_buttons;
   endfunction

   task automatic run_idle_ticks(int count);
      req_type item;
      repeat (count) begin
         item.start_poll = 1'b0;
         item.pin_level = 1'($urandom);
         send_tick(item);
      end
   endtask

   task automatic run_poll(logic [15:0] pressed_bits, int start_pct, int noise_pct);
      req_type item;
      item.start_poll = 1'b1;
      item.pin_level = 1'($urandom);
      send_tick(item);
      while (pad_phase != PH_IDLE) begin
         item.start_poll = ($urandom_range(99) < start_pct);
         if (pad_phase == PH_HIGH && $urandom_range(99) >= noise_pct) begin
            item.pin_level = ~pressed_bits[pad_bit[3:0]];
         end else begin
            item.pin_level = 1'($urandom);
         end
         send_tick(item);
      end
   endtask

   task automatic test_reset_timing();
      run_idle_ticks(2);
      run_poll(choose_buttons(), 20, 0);
   endtask

   task automatic test_directed_polls();
      program_register(REG_LATCH_TICKS, 8'd1);
      program_register(REG_HALF_BIT_TICKS, 8'd1);
      send_tick(req_type'{start_poll: 1'b0, pin_level: 1'b0});
      send_tick(req_type'{start_poll: 1'b0, pin_level: 1'b1});
      send_tick(req_type'{start_poll: 1'b0, pin_level: 1'b0});
      // Start stays high through the whole poll, the report tick included.
      run_poll(line_order(8'hff, 8'hff), 100, 0);
      run_poll(line_order(8'h00, 8'h00), 0, 0);
      run_poll(line_order(8'h00, 8'h00), 0, 0);
      run_poll(line_order(8'h0f, 8'h1f), 0, 0);
      run_poll(line_order(8'h05, 8'he0), 0, 0);
   endtask

   task automatic test_random_polls(int settings, int polls);
      repeat (settings) begin
         program_register(REG_LATCH_TICKS, 8'($urandom_range(1, 16)));
         program_register(REG_HALF_BIT_TICKS, 8'($urandom_range(1, 3)));
         repeat (polls) begin
            run_idle_ticks($urandom_range(0, 4));
            run_poll(choose_buttons(), $urandom_range(0, 40),
                     ($urandom_range(3) == 0) ? 20 : 0);
         end
      end
   endtask

   task automatic test_longest_timing();
      program_register(REG_LATCH_TICKS, 8'd255);
      program_register(REG_HALF_BIT_TICKS, 8'd1);
      run_poll(choose_buttons(), 10, 0);
   endtask

   task automatic test_zero_registers();
      program_register(REG_LATCH_TICKS, 8'd0);
      program_register(REG_HALF_BIT_TICKS, 8'd0);
      run_poll(choose_buttons(), 10, 0);
   endtask

   task automatic test_receiver_stall();
      program_register(REG_LATCH_TICKS, 8'd2);
      program_register(REG_HALF_BIT_TICKS, 8'd2);
      stall_request <= 1'b1;
      run_poll(choose_buttons(), 10, 0);
   endtask

   initial begin
      sender_idle_pct = 22;
      receiver_idle_pct = 47;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_timing();
      test_directed_polls();
      test_random_polls(2, 2);
      sender_idle_pct = 47;
      receiver_idle_pct = 22;
      test_longest_timing();
      test_zero_registers();
      test_random_polls(2, 2);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      test_receiver_stall();
      test_random_polls(2, 2);
      req_valid <= 1'b0;
      for (int n = 0; n < 2000 && outputs_due.size() != 0; n++) @(posedge clock);
      repeat (4) @(posedge clock);
      if (outputs_due.size() != 0) begin
         note_failure("Predicted output items never arrived");
      end
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/gsrp_pkg.sv
rtl/gsrp_sequencer.sv
rtl/gsrp_skid.sv
rtl/gamepad_shift_register_poller.sv
dv/testbench.sv
